[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared widths, request and result codes, and the command and status
// bundles that join the allocator controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  // field widths
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 13;
  localparam int PIDX_W    = 12;
  localparam int REQ_W     = 3;
  localparam int CFG_IDX_W = 2;

  // one map row holds this many page bits
  localparam int ROW_BITS = 8;
  localparam int BIT_W    = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MARK_USED = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MARK_FREE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TEST      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 2'd2;

  // result selects
  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_FAIL  = 3'd0;
  localparam logic [RES_W-1:0] RES_OOB   = 3'd1;
  localparam logic [RES_W-1:0] RES_DONE  = 3'd2;
  localparam logic [RES_W-1:0] RES_ALLOC = 3'd3;
  localparam logic [RES_W-1:0] RES_TEST  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic             load_req;
    logic             clr_write;
    logic             scan_start;
    logic             scan_step;
    logic             mark_init;
    logic             mark_fill;
    logic             mark_read;
    logic             mark_write;
    logic             single_read;
    logic             single_write;
    logic             res_load;
    logic [RES_W-1:0] res_sel;
    logic             out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             clr_last;
    logic [REQ_W-1:0] req_type;
    logic             alloc_zero;
    logic             single_ok;
    logic             scan_hit;
    logic             scan_last;
    logic             mark_inner;
    logic             mark_last;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for the page allocator: clearing pass, request decode, first-fit
// scan, run marking, single-page access and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_MINIT  = 4'd4;
  localparam logic [3:0] S_MARK   = 4'd5;
  localparam logic [3:0] S_MWR    = 4'd6;
  localparam logic [3:0] S_SINGLE = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.req_type)
          bpa_pkg::REQ_ALLOC: begin
            if (sts.alloc_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bpa_pkg::RES_FAIL;
              state_next   = S_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          bpa_pkg::REQ_FREE, bpa_pkg::REQ_MARK_USED, bpa_pkg::REQ_MARK_FREE: begin
            if (sts.single_ok) begin
              cmd.single_read = 1'b1;
              state_next      = S_SINGLE;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bpa_pkg::RES_FAIL;
              state_next   = S_RESP;
            end
          end
          bpa_pkg::REQ_TEST: begin
            if (sts.single_ok) begin
              cmd.single_read = 1'b1;
              state_next      = S_SINGLE;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bpa_pkg::RES_OOB;
              state_next   = S_RESP;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = bpa_pkg::RES_FAIL;
            state_next   = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          state_next = S_MINIT;
        end else if (sts.scan_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = bpa_pkg::RES_FAIL;
          state_next   = S_RESP;
        end
      end
      S_MINIT: begin
        cmd.mark_init = 1'b1;
        state_next    = S_MARK;
      end
      S_MARK: begin
        // rows fully inside the run are written without a read
        if (sts.mark_inner) begin
          cmd.mark_fill = 1'b1;
        end else begin
          cmd.mark_read = 1'b1;
          state_next    = S_MWR;
        end
      end
      S_MWR: begin
        cmd.mark_write = 1'b1;
        if (sts.mark_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = bpa_pkg::RES_ALLOC;
          state_next   = S_RESP;
        end else begin
          state_next = S_MARK;
        end
      end
      S_SINGLE: begin
        cmd.res_load = 1'b1;
        if (sts.req_type == bpa_pkg::REQ_TEST) begin
          cmd.res_sel = bpa_pkg::RES_TEST;
        end else begin
          cmd.single_write = 1'b1;
          cmd.res_sel      = bpa_pkg::RES_DONE;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/bpa_datapath.sv]
// ----------------------------------------------------------------------------
// bpa_datapath
// Page map memory, request registers, range checks, first-fit run counter,
// run marking and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_datapath #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [bpa_pkg::REQ_W-1:0]     req_type,
  input  wire logic [bpa_pkg::CNT_W-1:0]     run_length,
  input  wire logic [bpa_pkg::ADDR_W-1:0]    free_addr,
  input  wire logic [bpa_pkg::PIDX_W-1:0]    page_index,
  input  wire logic [bpa_pkg::ADDR_W-1:0]    region_base,
  input  wire logic [bpa_pkg::ADDR_W-1:0]    region_end,
  input  wire logic [bpa_pkg::CNT_W-1:0]     total_pages,
  input  wire bpa_pkg::cmd_t                 cmd,
  output bpa_pkg::sts_t                      sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_status,
  output logic [bpa_pkg::ADDR_W-1:0]         out_addr,
  output logic                               out_bit
);

  localparam int AW       = bpa_pkg::ADDR_W;
  localparam int CW       = bpa_pkg::CNT_W;
  localparam int RB       = bpa_pkg::ROW_BITS;
  localparam int BW       = bpa_pkg::BIT_W;
  localparam int NUM_ROWS = (MAX_PAGES + RB - 1) / RB;
  localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int IDX_W    = ROW_W + BW;
  localparam int PB_SH    = $clog2(PAGE_BYTES);

  // latched request
  logic [bpa_pkg::REQ_W-1:0]  q_type;
  logic [CW-1:0]              q_count;
  logic [AW-1:0]              q_addr;
  logic [bpa_pkg::PIDX_W-1:0] q_index;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      q_type  <= req_type;
      q_count <= run_length;
      q_addr  <= free_addr;
      q_index <= page_index;
    end
  end

  // effective page count
  logic [CW-1:0] live_pages;
  assign live_pages = (AW'(total_pages) < AW'(MAX_PAGES)) ? total_pages : CW'(MAX_PAGES);

  // single page target and range checks
  logic [AW-1:0]    addr_off;
  logic [AW-1:0]    page_wide;
  logic [AW-1:0]    idx_wide;
  logic [AW-1:0]    tgt_wide;
  logic             free_ok;
  logic             idx_ok;
  logic [IDX_W-1:0] tgt_idx;
  logic [ROW_W-1:0] tgt_row;
  logic [BW-1:0]    tgt_bit;

  assign addr_off  = q_addr - region_base;
  assign page_wide = addr_off >> PB_SH;
  assign idx_wide  = AW'(q_index);
  assign free_ok   = (q_addr >= region_base) && (q_addr < region_end) &&
                     (q_addr[PB_SH-1:0] == '0) && (page_wide < AW'(live_pages));
  assign idx_ok    = idx_wide < AW'(live_pages);
  assign tgt_wide  = (q_type == bpa_pkg::REQ_FREE) ? page_wide : idx_wide;
  assign tgt_idx   = tgt_wide[IDX_W-1:0];
  assign tgt_row   = tgt_idx[IDX_W-1:BW];
  assign tgt_bit   = tgt_idx[BW-1:0];

  // page map memory
  logic [RB-1:0]    map_mem [NUM_ROWS];
  logic [RB-1:0]    rd_data;
  logic             rd_en;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  logic [RB-1:0]    wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
  end

  // clearing pass after reset, every page used
  logic [ROW_W-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clr_write) begin
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  // first-fit scan over one row of pages
  logic [ROW_W-1:0] scan_row;
  logic [CW-1:0]    run;
  logic [CW-1:0]    run_v;
  logic             found;
  logic [BW-1:0]    hit_pos;
  logic             scan_last;
  logic             scan_adv;
  logic [IDX_W-1:0] end_page;

  always_comb begin
    logic [IDX_W-1:0] pg;
    logic             used;
    run_v   = run;
    found   = 1'b0;
    hit_pos = '0;
    for (int j = 0; j < RB; j++) begin
      pg   = {scan_row, BW'(j)};
      used = rd_data[j] | (AW'(pg) >= AW'(live_pages));
      if (!found) begin
        if (used) begin
          run_v = '0;
        end else begin
          run_v = run_v + CW'(1);
        end
        if (run_v == q_count) begin
          found   = 1'b1;
          hit_pos = BW'(j);
        end
      end
    end
  end

  assign scan_last = ((AW'(scan_row) + AW'(1)) << BW) >= AW'(live_pages);
  assign scan_adv  = cmd.scan_step && !found && !scan_last;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_row <= '0;
      run      <= '0;
    end else if (scan_adv) begin
      scan_row <= scan_row + ROW_W'(1);
      run      <= run_v;
    end
    if (cmd.scan_step && found) begin
      end_page <= {scan_row, hit_pos};
    end
  end

  // run marking
  logic [IDX_W-1:0] first_calc;
  logic [IDX_W-1:0] first_page;
  logic [ROW_W-1:0] mark_row;
  logic [ROW_W-1:0] first_row;
  logic [ROW_W-1:0] end_row;
  logic             mark_last;
  logic             mark_inner;
  logic [RB-1:0]    mark_mask;
  logic [AW-1:0]    alloc_addr;

  assign first_calc = IDX_W'(AW'(end_page) + AW'(1) - AW'(q_count));
  assign first_row  = first_page[IDX_W-1:BW];
  assign end_row    = end_page[IDX_W-1:BW];
  assign mark_last  = mark_row == end_row;
  assign mark_inner = (mark_row != first_row) && !mark_last;

  always_comb begin
    logic [IDX_W-1:0] pg;
    mark_mask = '0;
    for (int j = 0; j < RB; j++) begin
      pg           = {mark_row, BW'(j)};
      mark_mask[j] = (pg >= first_page) && (pg <= end_page);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_init) begin
      first_page <= first_calc;
      mark_row   <= first_calc[IDX_W-1:BW];
    end else if (cmd.mark_fill || cmd.mark_write) begin
      mark_row <= mark_row + ROW_W'(1);
    end
    alloc_addr <= region_base + (AW'(first_page) << PB_SH);
  end

  // single page update
  logic [RB-1:0] single_row;

  always_comb begin
    single_row          = rd_data;
    single_row[tgt_bit] = (q_type == bpa_pkg::REQ_MARK_USED);
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    priority if (cmd.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (scan_adv) begin
      rd_en   = 1'b1;
      rd_addr = scan_row + ROW_W'(1);
    end else if (cmd.mark_read) begin
      rd_en   = 1'b1;
      rd_addr = mark_row;
    end else if (cmd.single_read) begin
      rd_en   = 1'b1;
      rd_addr = tgt_row;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '1;
    priority if (cmd.clr_write) begin
      wr_en   = 1'b1;
      wr_addr = clr_row;
    end else if (cmd.mark_fill) begin
      wr_en   = 1'b1;
      wr_addr = mark_row;
    end else if (cmd.mark_write) begin
      wr_en   = 1'b1;
      wr_addr = mark_row;
      wr_data = rd_data | mark_mask;
    end else if (cmd.single_write) begin
      wr_en   = 1'b1;
      wr_addr = tgt_row;
      wr_data = single_row;
    end
  end

  // pending result
  logic          res_status;
  logic [AW-1:0] res_addr;
  logic          res_bit;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        bpa_pkg::RES_OOB: begin
          res_status <= 1'b1;
          res_addr   <= '0;
          res_bit    <= 1'b1;
        end
        bpa_pkg::RES_DONE: begin
          res_status <= 1'b0;
          res_addr   <= '0;
          res_bit    <= 1'b0;
        end
        bpa_pkg::RES_ALLOC: begin
          res_status <= 1'b0;
          res_addr   <= alloc_addr;
          res_bit    <= 1'b0;
        end
        bpa_pkg::RES_TEST: begin
          res_status <= 1'b0;
          res_addr   <= '0;
          res_bit    <= rd_data[tgt_bit];
        end
        default: begin
          res_status <= 1'b1;
          res_addr   <= '0;
          res_bit    <= 1'b0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_bit    <= res_bit;
    end
  end

  // status to controller
  always_comb begin
    sts            = '0;
    sts.clr_last   = clr_row == ROW_W'(NUM_ROWS - 1);
    sts.req_type   = q_type;
    sts.alloc_zero = q_count == '0;
    sts.single_ok  = (q_type == bpa_pkg::REQ_FREE) ? free_ok : idx_ok;
    sts.scan_hit   = found;
    sts.scan_last  = scan_last;
    sts.mark_inner = mark_inner;
    sts.mark_last  = mark_last;
    sts.out_free   = !out_valid || out_ready;
  end

  // checks
  a_rd_in_range : assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (AW'(rd_addr) < AW'(NUM_ROWS)))
    else $error("map read beyond last row");

  a_run_fits : assert property (@(posedge clk) disable iff (rst)
    cmd.mark_init |-> ((AW'(end_page) + AW'(1)) >= AW'(q_count)))
    else $error("found run shorter than requested length");

  a_mark_bound : assert property (@(posedge clk) disable iff (rst)
    (cmd.mark_fill || cmd.mark_write) |-> (mark_row <= end_row))
    else $error("run marking past its last row");

  a_out_free : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

[sv/bitmap_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// First-fit bitmap page frame allocator with stream request and result ports.
// ----------------------------------------------------------------------------
// One word in gives one word out. After reset the map is swept to all used,
// one row of 8 pages per cycle; no request is taken meanwhile, configuration
// writes are. Mark, free and test go through decode and one read of the
// target row, written back for mark and free, before the result is loaded.
// An allocation scans the map at one row of 8 pages per cycle through the
// single map read port to find or miss a run, then marks it after a setup
// state: the run's first and last rows are read and written back (once when
// the run sits in one row) and the rows between them are written without a
// read. The next request is taken while a result waits in the output
// register. PAGE_BYTES must be a power of two.
`default_nettype none

module bitmap_page_allocator_top #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request: tuser = req_type[2:0]
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [63:0]                       s_tdata,  // run_length[12:0], free_addr[44:13], page_index[56:45]
  input  wire logic [bpa_pkg::REQ_W-1:0]         s_tuser,  // req_type[2:0]
  // result
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [39:0]                            m_tdata,  // status[0], page_addr[32:1], bit_value[33]
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bpa_pkg::ADDR_W-1:0]        cfg_data
);

  localparam int AW = bpa_pkg::ADDR_W;
  localparam int CW = bpa_pkg::CNT_W;

  // configuration registers
  logic [AW-1:0] region_base;
  logic [AW-1:0] region_end;
  logic [CW-1:0] total_pages;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_end  <= '0;
      total_pages <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpa_pkg::CFG_REGION_BASE: region_base <= cfg_data;
        bpa_pkg::CFG_REGION_END:  region_end  <= cfg_data;
        bpa_pkg::CFG_TOTAL_PAGES: total_pages <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // controller and datapath
  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;
  logic          out_status;
  logic [AW-1:0] out_addr;
  logic          out_bit;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req_type    (s_tuser),
    .run_length  (s_tdata[12:0]),
    .free_addr   (s_tdata[44:13]),
    .page_index  (s_tdata[56:45]),
    .region_base (region_base),
    .region_end  (region_end),
    .total_pages (total_pages),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_status  (out_status),
    .out_addr    (out_addr),
    .out_bit     (out_bit)
  );

  // result word packing
  assign m_tdata = {6'b0, out_bit, out_addr, out_status};

endmodule

`default_nettype wire
